### src/psb_pkg.sv
package psb_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int DEST_ADDR_BITS_DEF  = 18;

    localparam int FRAME_W_LANDSCAPE = 320;
    localparam int FRAME_W_PORTRAIT  = 240;

    localparam int FLAG_MIRROR      = 0;
    localparam int FLAG_TRANSPARENT = 1;
    localparam int FLAG_LANDSCAPE   = 2;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 11;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_X      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_Y      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_STRIDE = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEST_X        = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEST_Y        = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BLIT_WIDTH    = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BLIT_HEIGHT   = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FLAG_BITS     = 3'd7;

    localparam logic MODE_PALETTE = 1'b0;
    localparam logic MODE_PIXEL   = 1'b1;

    typedef struct packed {
        logic [9:0]  source_x;
        logic [9:0]  source_y;
        logic [10:0] source_stride;
        logic [8:0]  dest_x;
        logic [8:0]  dest_y;
        logic [9:0]  blit_width;
        logic [9:0]  blit_height;
        logic [2:0]  flag_bits;
    } psb_cfg_t;

    // one item in flight between the scan stage and the result stage
    typedef struct packed {
        logic       mode;
        logic       in_blit;
        logic       last;
        logic [9:0] col;
        logic [9:0] row;
        logic [7:0] pixel_index;
    } psb_item_t;

endpackage

### src/palette_sprite_blitter.sv
// Palette sprite blitter, RGB565 frame buffer.
// Input stream s_axis: tuser is the mode; mode 0 words load a palette entry from an
// 8-bit red/green/blue triple, mode 1 words present one source pixel index. Pixels come
// column by column, rows inner; the block keeps its own column/row counters.
// Output stream m_axis: one result word per input word (palette loads give all zeros).
// tdata carries frame address, byte-swapped RGB565 color and sheet address; tuser is the
// frame buffer write enable; tlast marks the final pixel of the blit.
// cfg channel: register writes (index, data), always ready; write only while idle.
// Path: an accepted word is held in the scan register and the palette read register, then
// moves into the result register once the result register is free.
// Throughput: one word per cycle while m_axis_tready is high; the scan register, the
// palette read register and the result register form a two-stage pipeline, with the
// 11x11 sheet-address multiply between the palette read and the result register.
// Reset: counters cleared, registers at defaults (stride 1, all else 0); palette
// contents undefined until loaded.
// Stall: when m_axis_tready is low the result word holds; s_axis_tready drops only when
// both stages are full.
module palette_sprite_blitter
    import psb_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
    parameter int DEST_ADDR_BITS  = DEST_ADDR_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue, [39:32] pixel_index
    input  logic [39:0]               s_axis_tdata,
    // [0] mode
    input  logic                      s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [17:0] dest_address, [33:18] pixel_color, [53:34] source_address, [55:54] zero
    output logic [55:0]               m_axis_tdata,
    // [0] write_enable
    output logic                      m_axis_tuser,
    output logic                      m_axis_tlast,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    psb_cfg_t    cfg_reg;
    psb_cfg_t    cfg_next;
    psb_item_t   item;
    logic        item_valid;
    logic        take;
    logic        load;
    logic [15:0] palette_data;
    logic        write_enable;
    logic [17:0] dest_address;
    logic [15:0] pixel_color;
    logic [19:0] source_address;

    assign cfg_ready     = 1'b1;
    assign load          = item_valid && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !item_valid || load;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SOURCE_X:      cfg_next.source_x      = cfg_data[9:0];
                CFG_SOURCE_Y:      cfg_next.source_y      = cfg_data[9:0];
                CFG_SOURCE_STRIDE: cfg_next.source_stride = cfg_data[10:0];
                CFG_DEST_X:        cfg_next.dest_x        = cfg_data[8:0];
                CFG_DEST_Y:        cfg_next.dest_y        = cfg_data[8:0];
                CFG_BLIT_WIDTH:    cfg_next.blit_width    = cfg_data[9:0];
                CFG_BLIT_HEIGHT:   cfg_next.blit_height   = cfg_data[9:0];
                CFG_FLAG_BITS:     cfg_next.flag_bits     = cfg_data[2:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{source_x: 10'd0, source_y: 10'd0, source_stride: 11'd1,
                         dest_x: 9'd0, dest_y: 9'd0, blit_width: 10'd0,
                         blit_height: 10'd0, flag_bits: 3'd0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    psb_palette #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_palette (
        .clk      (clk),
        .wr_en    (take && (s_axis_tuser == MODE_PALETTE)),
        .wr_index (s_axis_tdata[7:0]),
        .red      (s_axis_tdata[15:8]),
        .green    (s_axis_tdata[23:16]),
        .blue     (s_axis_tdata[31:24]),
        .rd_en    (take),
        .rd_index (s_axis_tdata[39:32]),
        .rd_data  (palette_data)
    );

    psb_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .advance     (load),
        .mode        (s_axis_tuser),
        .pixel_index (s_axis_tdata[39:32]),
        .blit_width  (cfg_reg.blit_width),
        .blit_height (cfg_reg.blit_height),
        .item        (item),
        .item_valid  (item_valid)
    );

    psb_result #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES),
        .DEST_ADDR_BITS (DEST_ADDR_BITS)
    ) u_result (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .out_ready      (m_axis_tready),
        .item           (item),
        .cfg            (cfg_reg),
        .palette_data   (palette_data),
        .out_valid      (m_axis_tvalid),
        .write_enable   (write_enable),
        .dest_address   (dest_address),
        .pixel_color    (pixel_color),
        .source_address (source_address),
        .last_pixel     (m_axis_tlast)
    );

    assign m_axis_tuser = write_enable;
    assign m_axis_tdata = {2'b00, source_address, pixel_color, dest_address};

endmodule

### src/psb_palette.sv
module psb_palette
    import psb_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        wr_en,
    input  logic [7:0]  wr_index,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic        rd_en,
    input  logic [7:0]  rd_index,
    output logic [15:0] rd_data
);

    localparam int AddrBits = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    logic [15:0] mem [PALETTE_ENTRIES];
    logic [15:0] rd_data_reg;
    logic [15:0] rgb565;
    logic [15:0] swapped;
    logic        wr_in_range;

    always_comb
    begin
        rgb565      = {red[7:3], green[7:2], blue[7:3]};
        swapped     = {rgb565[7:0], rgb565[15:8]};
        wr_in_range = ({1'b0, wr_index} < 9'(PALETTE_ENTRIES));
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in_range)
        begin
            mem[wr_index[AddrBits-1:0]] <= swapped;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_index[AddrBits-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/psb_scan.sv
module psb_scan
    import psb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic       advance,
    input  logic       mode,
    input  logic [7:0] pixel_index,
    input  logic [9:0] blit_width,
    input  logic [9:0] blit_height,
    output psb_item_t  item,
    output logic       item_valid
);

    logic [9:0] col_reg;
    logic [9:0] col_next;
    logic [9:0] row_reg;
    logic [9:0] row_next;
    logic       valid_reg;
    logic       valid_next;
    psb_item_t  item_reg;
    psb_item_t  item_next;
    logic [10:0] row_inc;
    logic [10:0] col_inc;
    logic        in_blit;

    always_comb
    begin
        in_blit  = (col_reg < blit_width) && (row_reg < blit_height);
        row_inc  = 11'(row_reg) + 11'd1;
        col_inc  = 11'(col_reg) + 11'd1;
        col_next = col_reg;
        row_next = row_reg;

        item_next.mode        = mode;
        item_next.in_blit     = in_blit;
        item_next.last        = 1'b0;
        item_next.col         = col_reg;
        item_next.row         = row_reg;
        item_next.pixel_index = pixel_index;

        if (mode == MODE_PIXEL)
        begin
            if (!in_blit)
            begin
                item_next.last = 1'b1;
                col_next       = '0;
                row_next       = '0;
            end
            else if (row_inc >= 11'(blit_height))
            begin
                row_next = '0;
                if (col_inc >= 11'(blit_width))
                begin
                    col_next       = '0;
                    item_next.last = 1'b1;
                end
                else
                begin
                    col_next = col_inc[9:0];
                end
            end
            else
            begin
                row_next = row_inc[9:0];
            end
        end

        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (take)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

### src/psb_result.sv
module psb_result
    import psb_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
    parameter int DEST_ADDR_BITS  = DEST_ADDR_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic        out_ready,
    input  psb_item_t   item,
    input  psb_cfg_t    cfg,
    input  logic [15:0] palette_data,
    output logic        out_valid,
    output logic        write_enable,
    output logic [17:0] dest_address,
    output logic [15:0] pixel_color,
    output logic [19:0] source_address,
    output logic        last_pixel
);

    localparam logic [23:0] DestMask = 24'((64'd1 << DEST_ADDR_BITS) - 64'd1);

    logic        valid_reg;
    logic        valid_next;
    logic        we_reg;
    logic        we_next;
    logic [17:0] daddr_reg;
    logic [17:0] daddr_next;
    logic [15:0] color_reg;
    logic [15:0] color_next;
    logic [19:0] saddr_reg;
    logic [19:0] saddr_next;
    logic        last_reg;
    logic        last_next;

    logic [10:0] src_row;
    logic [21:0] src_prod;
    logic [10:0] dst_row;
    logic [23:0] row_base;
    logic [23:0] dst_col;
    logic [23:0] dst_sum;
    logic        opaque;
    logic        idx_ok;

    always_comb
    begin
        src_row  = 11'(cfg.source_y) + 11'(item.row);
        src_prod = 22'(src_row) * 22'(cfg.source_stride);
        dst_row  = 11'(cfg.dest_y) + 11'(item.row);
        if (cfg.flag_bits[FLAG_LANDSCAPE])
        begin
            row_base = 24'(dst_row) * 24'(FRAME_W_LANDSCAPE);
        end
        else
        begin
            row_base = 24'(dst_row) * 24'(FRAME_W_PORTRAIT);
        end
        if (cfg.flag_bits[FLAG_MIRROR])
        begin
            dst_col = 24'(cfg.dest_x) + 24'(cfg.blit_width) - 24'd1 - 24'(item.col);
        end
        else
        begin
            dst_col = 24'(cfg.dest_x) + 24'(item.col);
        end
        dst_sum = (row_base + dst_col) & DestMask;
        opaque  = !(cfg.flag_bits[FLAG_TRANSPARENT] && (item.pixel_index == 8'd0));
        idx_ok  = ({1'b0, item.pixel_index} < 9'(PALETTE_ENTRIES));

        we_next    = 1'b0;
        daddr_next = '0;
        color_next = '0;
        saddr_next = '0;
        last_next  = 1'b0;
        if (item.mode == MODE_PIXEL)
        begin
            saddr_next = src_prod[19:0] + 20'(cfg.source_x) + 20'(item.col);
            last_next  = item.last;
            if (item.in_blit)
            begin
                daddr_next = dst_sum[17:0];
                if (opaque)
                begin
                    we_next    = 1'b1;
                    color_next = idx_ok ? palette_data : 16'd0;
                end
            end
        end

        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            we_reg    <= we_next;
            daddr_reg <= daddr_next;
            color_reg <= color_next;
            saddr_reg <= saddr_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid      = valid_reg;
    assign write_enable   = we_reg;
    assign dest_address   = daddr_reg;
    assign pixel_color    = color_reg;
    assign source_address = saddr_reg;
    assign last_pixel     = last_reg;

endmodule
